>>> rtl/prs_pkg.sv
// shared types, widths and register codes for the pairwise repulsion force pipeline
// no dependencies; imported by prs_sqrt_step, prs_div_step and pairwise_repulsion_force
`default_nettype none

package prs_pkg;

   // field and datapath widths
   localparam int COORD_W   = 32;
   localparam int MAG_W     = 32;
   localparam int SQ_W      = 64;
   localparam int PROD_W    = 64;
   localparam int Q_W       = 66;
   localparam int A_W       = 67;
   localparam int A_LO_W    = 32;
   localparam int A_HI_W    = A_W - A_LO_W;
   localparam int ROOT_W    = 33;
   localparam int REM_W     = 36;
   localparam int B_W       = 34;
   localparam int PLO_W     = A_LO_W + B_W;
   localparam int PHI_W     = A_HI_W + B_W;
   localparam int DENOM_W   = A_W + B_W;
   localparam int RMD_W     = PROD_W + 32;
   localparam int QUO_W     = 32;
   localparam int DVS_W     = DENOM_W + QUO_W - 1;
   localparam int AXES      = 3;
   localparam int SQRT_STEPS = 33;
   localparam int DIV_STEPS  = QUO_W;

   // configuration port
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_DATA_W-1:0] SOFTENING_RESET = 32'd66;
   localparam logic [CSR_DATA_W-1:0] STRENGTH_RESET  = 32'd65536;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SOFTENING = 4'd0,
      CSR_STRENGTH  = 4'd1
   } csr_index_type;

   // channel payloads
   typedef struct packed {
      logic signed [COORD_W-1:0] first_x;
      logic signed [COORD_W-1:0] first_y;
      logic signed [COORD_W-1:0] first_z;
      logic signed [COORD_W-1:0] second_x;
      logic signed [COORD_W-1:0] second_y;
      logic signed [COORD_W-1:0] second_z;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] force_x;
      logic signed [COORD_W-1:0] force_y;
      logic signed [COORD_W-1:0] force_z;
      logic                      clipped;
      logic                      degenerate;
   } rsp_type;

   // pipeline stage contents
   typedef struct packed {
      logic [AXES-1:0][MAG_W-1:0] mag;
      logic [AXES-1:0]            sneg;
   } diff_stage_type;

   typedef struct packed {
      logic [AXES-1:0][SQ_W-1:0]   sq;
      logic [AXES-1:0][PROD_W-1:0] prod;
      logic [AXES-1:0]             sneg;
   } mul_stage_type;

   typedef struct packed {
      logic [Q_W-1:0]              q;
      logic [A_W-1:0]              a;
      logic [REM_W-1:0]            rem;
      logic [ROOT_W-1:0]           root;
      logic [AXES-1:0][PROD_W-1:0] prod;
      logic [AXES-1:0]             sneg;
   } sq_stage_type;

   typedef struct packed {
      logic [PLO_W-1:0]            plo;
      logic [PHI_W-1:0]            phi;
      logic [AXES-1:0][PROD_W-1:0] prod;
      logic [AXES-1:0]             sneg;
      logic                        degen;
   } den1_stage_type;

   typedef struct packed {
      logic [DENOM_W-1:0]          denom;
      logic [AXES-1:0][PROD_W-1:0] prod;
      logic [AXES-1:0]             sneg;
      logic                        degen;
   } den2_stage_type;

   typedef struct packed {
      logic [DENOM_W-1:0]         denom;
      logic [AXES-1:0][RMD_W-1:0] rmd;
      logic [AXES-1:0][QUO_W-1:0] quo;
      logic [AXES-1:0]            ovf;
      logic [AXES-1:0]            sneg;
      logic                       degen;
   } dv_stage_type;

endpackage

`default_nettype wire

>>> rtl/prs_sqrt_step.sv
// one digit of the pipelined integer square root (restoring, two bits of radicand)
// depends on prs_pkg for the stage struct
`default_nettype none

module prs_sqrt_step (
   input  prs_pkg::sq_stage_type stage_i,
   input  logic [1:0]            pair_i,
   output prs_pkg::sq_stage_type stage_o
);
   import prs_pkg::*;

   logic [REM_W-1:0] cur;
   logic [REM_W-1:0] trial;

   // bring down the next radicand pair and try the next root bit
   assign cur   = {stage_i.rem[REM_W-3:0], pair_i};
   assign trial = {1'b0, stage_i.root, 2'b01};

   always_comb begin
      stage_o = stage_i;
      if (cur >= trial) begin
         stage_o.rem  = cur - trial;
         stage_o.root = {stage_i.root[ROOT_W-2:0], 1'b1};
      end else begin
         stage_o.rem  = cur;
         stage_o.root = {stage_i.root[ROOT_W-2:0], 1'b0};
      end
   end

endmodule

`default_nettype wire

>>> rtl/prs_div_step.sv
// one quotient bit of the pipelined restoring divider, for all three axes
// depends on prs_pkg for the stage struct; divisor comes in already shifted
`default_nettype none

module prs_div_step (
   input  prs_pkg::dv_stage_type          stage_i,
   input  logic [prs_pkg::DVS_W-1:0]      divisor_i,
   output prs_pkg::dv_stage_type          stage_o
);
   import prs_pkg::*;

   // compare and subtract per axis, shift the bit into the quotient
   always_comb begin
      stage_o = stage_i;
      for (int c = 0; c < AXES; c++) begin
         if (DVS_W'(stage_i.rmd[c]) >= divisor_i) begin
            stage_o.rmd[c] = stage_i.rmd[c] - divisor_i[RMD_W-1:0];
            stage_o.quo[c] = {stage_i.quo[c][QUO_W-2:0], 1'b1};
         end else begin
            stage_o.quo[c] = {stage_i.quo[c][QUO_W-2:0], 1'b0};
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/pairwise_repulsion_force.sv
// Softened pairwise repulsion force, signed Q16.16, fully pipelined.
// req channel: one transfer carries two 3-D points (first, second). rsp channel:
// one transfer per request carries the force on the first point, a clipped flag
// (some axis saturated) and a degenerate flag (zero divisor, forces forced to 0).
// csr channel: index 0 writes softening, index 1 writes strength; other indexes
// are dropped. csr_ready is always high; write only while the pipeline is empty.
// Throughput: one pair per cycle while req_ready is high. Each request passes through 3
// front stages, 33 square root digit stages, 2 divisor product stages, 1 overflow check
// stage, 32 quotient bit stages and the output reg before its rsp transfer.
// A stalled receiver freezes the pipeline once an item reaches the last stage while
// the output register is held: a one-entry skid register takes that item, and
// req_ready drops while the skid is occupied. Nothing is lost or repeated.
// Reset (synchronous, active high) empties the pipeline and restores
// softening = 66 and strength = 1.0.
// Depends on prs_pkg, prs_sqrt_step and prs_div_step.
`default_nettype none

module pairwise_repulsion_force (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  prs_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output prs_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [prs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [prs_pkg::CSR_DATA_W-1:0]     csr_data
);
   import prs_pkg::*;

   localparam int NUM_STAGES = 2 + (SQRT_STEPS + 1) + 2 + (DIV_STEPS + 1);

   logic [CSR_DATA_W-1:0] softening_ff;
   logic [CSR_DATA_W-1:0] strength_ff;

   logic                  pipe_en;
   logic [NUM_STAGES-1:0] valid_ff, valid_in;

   diff_stage_type diff_ff, diff_in;
   mul_stage_type  mul_ff, mul_in;
   sq_stage_type   sq_ff [SQRT_STEPS+1];
   sq_stage_type   sq_in [SQRT_STEPS+1];
   den1_stage_type den1_ff, den1_in;
   den2_stage_type den2_ff, den2_in;
   dv_stage_type   dv_ff [DIV_STEPS+1];
   dv_stage_type   dv_in [DIV_STEPS+1];

   rsp_type result;
   rsp_type out_ff, out_in, skid_ff, skid_in;
   logic    out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         softening_ff <= SOFTENING_RESET;
         strength_ff  <= STRENGTH_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SOFTENING: softening_ff <= csr_data;
            CSR_STRENGTH:  strength_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // whole pipeline moves while the skid register is empty
   assign pipe_en   = !skid_valid_ff;
   assign req_ready = pipe_en;
   assign valid_in  = {valid_ff[NUM_STAGES-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (pipe_en) begin
         valid_ff <= valid_in;
      end
   end

   // stage: coordinate differences as magnitude, and force sign (difference sign xor strength sign)
   always_comb begin
      logic [COORD_W:0] d [AXES];
      logic [COORD_W:0] absd;
      d[0] = {req_data.first_x[COORD_W-1], req_data.first_x}
           - {req_data.second_x[COORD_W-1], req_data.second_x};
      d[1] = {req_data.first_y[COORD_W-1], req_data.first_y}
           - {req_data.second_y[COORD_W-1], req_data.second_y};
      d[2] = {req_data.first_z[COORD_W-1], req_data.first_z}
           - {req_data.second_z[COORD_W-1], req_data.second_z};
      diff_in = '0;
      for (int c = 0; c < AXES; c++) begin
         absd = d[c][COORD_W] ? ((COORD_W+1)'(0) - d[c]) : d[c];
         diff_in.mag[c]  = absd[MAG_W-1:0];
         diff_in.sneg[c] = d[c][COORD_W] ^ strength_ff[CSR_DATA_W-1];
      end
   end

   // stage: squares and force numerators
   always_comb begin
      logic [CSR_DATA_W-1:0] fmag;
      fmag = strength_ff[CSR_DATA_W-1] ? (CSR_DATA_W'(0) - strength_ff) : strength_ff;
      mul_in.sneg = diff_ff.sneg;
      for (int c = 0; c < AXES; c++) begin
         mul_in.sq[c]   = SQ_W'(diff_ff.mag[c]) * SQ_W'(diff_ff.mag[c]);
         mul_in.prod[c] = PROD_W'(fmag) * PROD_W'(diff_ff.mag[c]);
      end
   end

   // stage: squared distance and softened squared distance
   always_comb begin
      sq_in[0].q    = Q_W'(mul_ff.sq[0]) + Q_W'(mul_ff.sq[1]) + Q_W'(mul_ff.sq[2]);
      sq_in[0].a    = A_W'(sq_in[0].q) + A_W'({softening_ff, 16'b0});
      sq_in[0].rem  = '0;
      sq_in[0].root = '0;
      sq_in[0].prod = mul_ff.prod;
      sq_in[0].sneg = mul_ff.sneg;
   end

   // square root, one digit per stage, most significant pair first
   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
      localparam int LSB = 2 * (SQRT_STEPS - 1 - j);
      prs_sqrt_step u_step (
         .stage_i (sq_ff[j]),
         .pair_i  (sq_ff[j].q[LSB+1:LSB]),
         .stage_o (sq_in[j+1])
      );
   end

   // stage: divisor partial products
   always_comb begin
      logic [B_W-1:0] b;
      b = B_W'(softening_ff) + B_W'(sq_ff[SQRT_STEPS].root);
      den1_in.plo   = PLO_W'(sq_ff[SQRT_STEPS].a[A_LO_W-1:0]) * PLO_W'(b);
      den1_in.phi   = PHI_W'(sq_ff[SQRT_STEPS].a[A_W-1:A_LO_W]) * PHI_W'(b);
      den1_in.prod  = sq_ff[SQRT_STEPS].prod;
      den1_in.sneg  = sq_ff[SQRT_STEPS].sneg;
      den1_in.degen = (sq_ff[SQRT_STEPS].a == '0) || (b == '0);
   end

   // stage: full divisor
   always_comb begin
      den2_in.denom = (DENOM_W'(den1_ff.phi) << A_LO_W) + DENOM_W'(den1_ff.plo);
      den2_in.prod  = den1_ff.prod;
      den2_in.sneg  = den1_ff.sneg;
      den2_in.degen = den1_ff.degen;
   end

   // stage: quotient overflow check, numerator becomes the starting remainder
   always_comb begin
      dv_in[0].denom = den2_ff.denom;
      dv_in[0].sneg  = den2_ff.sneg;
      dv_in[0].degen = den2_ff.degen;
      dv_in[0].quo   = '0;
      for (int c = 0; c < AXES; c++) begin
         dv_in[0].ovf[c] = DENOM_W'(den2_ff.prod[c]) >= den2_ff.denom;
         dv_in[0].rmd[c] = {den2_ff.prod[c], 32'b0};
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      logic [DVS_W-1:0] dvs;
      assign dvs = DVS_W'(dv_ff[j].denom) << (DIV_STEPS - 1 - j);
      prs_div_step u_step (
         .stage_i   (dv_ff[j]),
         .divisor_i (dvs),
         .stage_o   (dv_in[j+1])
      );
   end

   // pipeline data registers
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         diff_ff <= diff_in;
         mul_ff  <= mul_in;
         for (int s = 0; s <= SQRT_STEPS; s++) begin
            sq_ff[s] <= sq_in[s];
         end
         den1_ff <= den1_in;
         den2_ff <= den2_in;
         for (int s = 0; s <= DIV_STEPS; s++) begin
            dv_ff[s] <= dv_in[s];
         end
      end
   end

   // saturation, sign and degenerate override
   always_comb begin
      logic [QUO_W-1:0]   lim, m, f [AXES];
      logic [AXES-1:0]    clip;
      for (int c = 0; c < AXES; c++) begin
         lim     = dv_ff[DIV_STEPS].sneg[c] ? 32'h8000_0000 : 32'h7fff_ffff;
         clip[c] = dv_ff[DIV_STEPS].ovf[c] || (dv_ff[DIV_STEPS].quo[c] > lim);
         m       = clip[c] ? lim : dv_ff[DIV_STEPS].quo[c];
         f[c]    = dv_ff[DIV_STEPS].sneg[c] ? (QUO_W'(0) - m) : m;
      end
      if (dv_ff[DIV_STEPS].degen) begin
         result = '0;
         result.degenerate = 1'b1;
      end else begin
         result.force_x    = f[0];
         result.force_y    = f[1];
         result.force_z    = f[2];
         result.clipped    = |clip;
         result.degenerate = 1'b0;
      end
   end

   // output register with one-entry skid
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (rsp_ready) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || rsp_ready) begin
         out_in       = result;
         out_valid_in = valid_ff[NUM_STAGES-1];
      end else if (valid_ff[NUM_STAGES-1]) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire
